FILE: rtl/sorted_deadline_timer_queue_unit_defines.svh
// assertion macros shared by the timer queue rtl
`ifndef SORTED_DEADLINE_TIMER_QUEUE_UNIT_DEFINES_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_UNIT_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define SDTQ_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// condition that must never be seen out of reset
`define SDTQ_NEVER(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error(msg);

`endif

FILE: rtl/sdtq_pkg.sv
package sdtq_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int LEN_W      = $clog2(SLOT_COUNT + 1);
  localparam int SLOT_W     = 4;
  localparam int TICK_W     = 32;
  localparam int KIND_W     = 2;

  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REG   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UNREG = 2'd2;

  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(SLOT_COUNT);

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [TICK_W-1:0] target;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [TICK_W-1:0] now;
    logic              last;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_SHD_RD,
    ST_SHD_WR,
    ST_INS_START,
    ST_INS_RD,
    ST_INS_CHK,
    ST_INS_WR,
    ST_EXP_RD,
    ST_EXP_CHK,
    ST_EXP_END
  } state_t;

  // logical queue position to ring address
  function automatic logic [IDX_W-1:0] qaddr(input logic [IDX_W-1:0] head,
                                             input logic [LEN_W-1:0] idx);
    logic [LEN_W:0] sum;
    sum = (LEN_W+1)'(head) + (LEN_W+1)'(idx);
    if (sum >= (LEN_W+1)'(SLOT_COUNT)) begin
      sum = sum - (LEN_W+1)'(SLOT_COUNT);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

FILE: rtl/sorted_deadline_timer_queue_unit.sv
// sorted deadline timer queue
// input channel (in_valid/in_ready): in_kind selects tick, register or unregister;
// in_slot_id goes with register and unregister, in_target_tick with register.
// a tick advances the 32-bit counter and returns one transfer on the out_ channel
// for each slot whose target is at or below the new count, in queue order, with
// out_last_of_run set on the final one; register and unregister return nothing.
// one item at a time: in_ready is high only while the sequencer is idle.
// the queue is a ring in one single-port-read ram, walked one entry at a time
// by one comparator.
// results leave through a one-deep output register; while the receiver stalls
// the sequencer holds the next expiry and waits, nothing is dropped.
// reset (rst_n low, synchronous) clears the counter and empties the queue,
// no clearing pass is needed.
`include "sorted_deadline_timer_queue_unit_defines.svh"

module sorted_deadline_timer_queue_unit
  import sdtq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [SLOT_W-1:0] in_slot_id,
  input  logic [TICK_W-1:0] in_target_tick,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SLOT_W-1:0] out_expired_slot,
  output logic [TICK_W-1:0] out_now_tick,
  output logic              out_last_of_run
);

  logic res_push;
  res_t res;
  logic push_ok;
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  sdtq_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_slot_id     (in_slot_id),
    .in_target_tick (in_target_tick),
    .res_push       (res_push),
    .res            (res),
    .push_ok        (push_ok)
  );

  // room when empty or when the held result transfers this cycle
  assign push_ok = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_expired_slot = out_res_r.slot;
  assign out_now_tick     = out_res_r.now;
  assign out_last_of_run  = out_res_r.last;

  `SDTQ_NEVER(a_busy_no_ready, clk, rst_n, in_ready && out_valid_r && res_push, "push while idle")

endmodule

FILE: rtl/sdtq_ram.sv
module sdtq_ram #(
  parameter int ADDR_W = 4,
  parameter int DATA_W = 36
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/sdtq_seq.sv
`include "sorted_deadline_timer_queue_unit_defines.svh"

module sdtq_seq
  import sdtq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [SLOT_W-1:0] in_slot_id,
  input  logic [TICK_W-1:0] in_target_tick,
  output logic              res_push,
  output res_t              res,
  input  logic              push_ok
);

  state_t state_r, state_nxt;

  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [TICK_W-1:0] target_r, target_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic [SLOT_W-1:0] pend_slot_r, pend_slot_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;

  logic [TICK_W-1:0] cmp_b;
  logic              rd_gt;
  logic              slot_hit;
  logic [LEN_W-1:0]  idx_inc;
  logic [LEN_W-1:0]  idx_dec;

  sdtq_ram #(
    .ADDR_W (IDX_W),
    .DATA_W (ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  // shared compare unit: against the new target while inserting, the counter while expiring
  assign cmp_b    = (state_r == ST_EXP_CHK) ? tick_r : target_r;
  assign rd_gt    = rd_entry.target > cmp_b;
  assign slot_hit = rd_entry.slot == slot_r;
  assign idx_inc  = idx_r + LEN_W'(1);
  assign idx_dec  = idx_r - LEN_W'(1);

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_kind) inside
            KIND_TICK:             state_nxt = ST_EXP_RD;
            KIND_REG, KIND_UNREG:  state_nxt = ST_FIND_RD;
            default:               state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FIND_RD: begin
        if (idx_r == len_r) begin
          state_nxt = (kind_r == KIND_REG) ? ST_INS_START : ST_IDLE;
        end else begin
          state_nxt = ST_FIND_CHK;
        end
      end
      ST_FIND_CHK: state_nxt = slot_hit ? ST_SHD_RD : ST_FIND_RD;
      ST_SHD_RD: begin
        if (idx_inc == len_r) begin
          state_nxt = (kind_r == KIND_REG) ? ST_INS_START : ST_IDLE;
        end else begin
          state_nxt = ST_SHD_WR;
        end
      end
      ST_SHD_WR:    state_nxt = ST_SHD_RD;
      ST_INS_START: state_nxt = (len_r == LEN_FULL) ? ST_IDLE : ST_INS_RD;
      ST_INS_RD:    state_nxt = (idx_r == '0) ? ST_INS_WR : ST_INS_CHK;
      ST_INS_CHK:   state_nxt = rd_gt ? ST_INS_RD : ST_INS_WR;
      ST_INS_WR:    state_nxt = ST_IDLE;
      ST_EXP_RD:    state_nxt = (len_r == '0) ? ST_EXP_END : ST_EXP_CHK;
      ST_EXP_CHK: begin
        if (rd_gt) begin
          state_nxt = ST_EXP_END;
        end else if (!pend_r || push_ok) begin
          state_nxt = ST_EXP_RD;
        end
      end
      ST_EXP_END: begin
        if (!pend_r || push_ok) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    kind_nxt      = kind_r;
    slot_nxt      = slot_r;
    target_nxt    = target_r;
    tick_nxt      = tick_r;
    head_nxt      = head_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pend_slot_nxt = pend_slot_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = rd_entry;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    res_push      = 1'b0;
    res           = '{slot: pend_slot_r, now: tick_r, last: 1'b0};
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt   = in_kind;
          slot_nxt   = in_slot_id;
          target_nxt = in_target_tick;
          idx_nxt    = '0;
          if (in_kind == KIND_TICK) begin
            tick_nxt = tick_r + TICK_W'(1);
          end
        end
      end
      ST_FIND_RD: begin
        if (idx_r != len_r) begin
          ram_re    = 1'b1;
          ram_raddr = qaddr(head_r, idx_r);
        end
      end
      ST_FIND_CHK: begin
        if (!slot_hit) begin
          idx_nxt = idx_inc;
        end
      end
      ST_SHD_RD: begin
        if (idx_inc == len_r) begin
          len_nxt = len_r - LEN_W'(1);
        end else begin
          ram_re    = 1'b1;
          ram_raddr = qaddr(head_r, idx_inc);
        end
      end
      ST_SHD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = qaddr(head_r, idx_r);
        idx_nxt   = idx_inc;
      end
      ST_INS_START: idx_nxt = len_r;
      // walk from the tail, moving up every entry with a later target
      ST_INS_RD: begin
        if (idx_r != '0) begin
          ram_re    = 1'b1;
          ram_raddr = qaddr(head_r, idx_dec);
        end
      end
      ST_INS_CHK: begin
        if (rd_gt) begin
          ram_we    = 1'b1;
          ram_waddr = qaddr(head_r, idx_r);
          idx_nxt   = idx_dec;
        end
      end
      ST_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = qaddr(head_r, idx_r);
        ram_wdata = '{slot: slot_r, target: target_r};
        len_nxt   = len_r + LEN_W'(1);
      end
      ST_EXP_RD: begin
        if (len_r != '0) begin
          ram_re    = 1'b1;
          ram_raddr = head_r;
        end
      end
      // an expired head is held back one step so the last of the run can be marked
      ST_EXP_CHK: begin
        if (!rd_gt && (!pend_r || push_ok)) begin
          res_push      = pend_r;
          pend_nxt      = 1'b1;
          pend_slot_nxt = rd_entry.slot;
          head_nxt      = qaddr(head_r, LEN_W'(1));
          len_nxt       = len_r - LEN_W'(1);
        end
      end
      ST_EXP_END: begin
        res.last = 1'b1;
        if (pend_r && push_ok) begin
          res_push = 1'b1;
          pend_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tick_r  <= '0;
      head_r  <= '0;
      len_r   <= '0;
      idx_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tick_r  <= tick_nxt;
      head_r  <= head_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    slot_r      <= slot_nxt;
    target_r    <= target_nxt;
    pend_slot_r <= pend_slot_nxt;
  end

  `SDTQ_ASSERT(a_len_bound, clk, rst_n, len_r <= LEN_FULL, "queue length beyond capacity")
  `SDTQ_NEVER(a_push_room, clk, rst_n, res_push && !push_ok, "result pushed into full buffer")
  `SDTQ_ASSERT(a_exp_shrink, clk, rst_n, (state_r == ST_EXP_CHK) |=> (len_r <= $past(len_r)), "queue grew while expiring")
  `SDTQ_ASSERT(a_tick_step, clk, rst_n, (in_valid && in_ready && in_kind == KIND_TICK) |=> (tick_r == $past(tick_r) + TICK_W'(1)), "tick counter did not advance")

endmodule

FILE: tb/tb.sv
module tb;
  import sdtq_pkg::*;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam int HOLD_CYCLES  = 120;
  localparam int RANDOM_ITEMS = 226;
  localparam int QUIET_FROM   = 180;

  class expiry_board;
    logic [TICK_W-1:0] now_count;
    logic [SLOT_W-1:0] q_slot[$];
    logic [TICK_W-1:0] q_target[$];
    res_t              due[$];
    int                errors;

    function new();
      now_count = '0;
      errors = 0;
    endfunction

    function void drop_slot(logic [SLOT_W-1:0] s);
      for (int i = 0; i < q_slot.size(); i++) begin
        if (q_slot[i] == s) begin
          q_slot.delete(i);
          q_target.delete(i);
          return;
        end
      end
    endfunction

    // called for every input transfer, queues the expiries a tick causes
    function void note_item(logic [KIND_W-1:0] k, logic [SLOT_W-1:0] s,
                            logic [TICK_W-1:0] t);
      int   pos;
      res_t r;
      case (k)
        KIND_REG: begin
          drop_slot(s);
          if (q_slot.size() < SLOT_COUNT) begin
            pos = 0;
            while (pos < q_slot.size() && q_target[pos] <= t) pos++;
            q_slot.insert(pos, s);
            q_target.insert(pos, t);
          end
        end
        KIND_UNREG: drop_slot(s);
        KIND_TICK: begin
          now_count = now_count + 1'b1;
          pos = due.size();
          while (q_slot.size() > 0 && q_target[0] <= now_count) begin
            r.slot = q_slot.pop_front();
            r.now  = now_count;
            r.last = 1'b0;
            void'(q_target.pop_front());
            due.push_back(r);
          end
          if (due.size() > pos) due[$].last = 1'b1;
        end
        default: ;
      endcase
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected expiry: slot %0d now %0d last %0b",
                   got.slot, got.now, got.last);
      end else begin
        want = due.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("expiry mismatch: expected slot %0d now %0d last %0b, got slot %0d now %0d last %0b",
                     want.slot, want.now, want.last, got.slot, got.now, got.last);
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [KIND_W-1:0] in_kind = KIND_TICK;
  logic [SLOT_W-1:0] in_slot_id = '0;
  logic [TICK_W-1:0] in_target_tick = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [SLOT_W-1:0] out_expired_slot;
  logic [TICK_W-1:0] out_now_tick;
  logic              out_last_of_run;

  bit          quiet_tail = 1'b0;
  bit          hold_go = 1'b0;
  expiry_board board = new();

  sorted_deadline_timer_queue_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_slot_id       (in_slot_id),
    .in_target_tick   (in_target_tick),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_expired_slot (out_expired_slot),
    .out_now_tick     (out_now_tick),
    .out_last_of_run  (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_item(input logic [KIND_W-1:0] k, input logic [SLOT_W-1:0] s,
                           input logic [TICK_W-1:0] t);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= k;
    in_slot_id     <= s;
    in_target_tick <= t;
    do @(posedge clk); while (!in_ready);
    board.note_item(k, s, t);
  endtask

  initial begin : result_sink
    int stall;
    bit held;
    stall = 0;
    held  = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        board.check_result('{slot: out_expired_slot, now: out_now_tick,
                             last: out_last_of_run});
      // one long hold-off once the queue is full so the block backs up and stalls its input
      if (hold_go && !held) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && !quiet_tail && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 3);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int                waited;
    int                pick;
    logic [KIND_W-1:0] k;
    logic [SLOT_W-1:0] s;
    logic [TICK_W-1:0] t;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_item(KIND_TICK, 4'd0, '0);
    send_item(KIND_NONE, 4'd15, '1);
    send_item(KIND_UNREG, 4'd7, '0);
    send_item(KIND_REG, 4'd15, '1);
    send_item(KIND_REG, 4'd0, '0);
    send_item(KIND_TICK, 4'd5, '0);
    // fill every slot with mixed due targets, slot 15 moves from the far end
    for (int i = 0; i < SLOT_COUNT; i++)
      send_item(KIND_REG, SLOT_W'(i),
                i[0] ? board.now_count + 1 : board.now_count - 1);
    // re-register while the queue is full
    send_item(KIND_REG, 4'd3, board.now_count);
    hold_go = 1'b1;
    send_item(KIND_TICK, 4'd9, '1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == QUIET_FROM) quiet_tail = 1'b1;
      pick = $urandom_range(0, 99);
      s = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
      t = $urandom;
      if (pick < 40) begin
        k = KIND_TICK;
      end else if (pick < 78) begin
        k = KIND_REG;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: t = board.now_count + $urandom_range(1, 6);
          6, 7: t = $urandom_range(0, board.now_count);
          default: ;
        endcase
      end else if (pick < 95) begin
        k = KIND_UNREG;
        if (board.q_slot.size() > 0 && $urandom_range(0, 2) != 0)
          s = board.q_slot[$urandom_range(0, board.q_slot.size() - 1)];
      end else begin
        k = KIND_NONE;
      end
      send_item(k, s, t);
    end
    in_valid <= 1'b0;

    waited = 0;
    while (board.due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (64) @(posedge clk);
    if (board.due.size() != 0) begin
      $display("%0d expected expiries never arrived", board.due.size());
      board.errors += board.due.size();
    end
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
